[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers used by the sequencer RTL (dcs_seq); empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// cons must hold in the same cycle as ante
`define DCS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// cons must hold in the cycle after ante
`define DCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define DCS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define DCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/dcs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcs_pkg
// Shared types, codes and default sizes of the 2D descriptor DMA sequencer.
// ----------------------------------------------------------------------------
package dcs_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int ADDR_WIDTH_DEF  = 16;
	localparam int COUNT_WIDTH_DEF = 16;
	localparam int DATA_WIDTH_DEF  = 32;

	// port field widths
	localparam int CMD_W   = 2;
	localparam int IDX_W   = 4;
	localparam int MODE_W  = 2;
	localparam int START_W = 16;
	localparam int CNT_W   = 16;
	localparam int STR_W   = 16;
	localparam int SDAT_W  = 32;
	localparam int KIND_W  = 2;
	localparam int RADDR_W = 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_START = 2'd2,
		CMD_SRST  = 2'd3
	} cmd_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_SUSPEND = 2'd0,
		MODE_XFER    = 2'd1,
		MODE_FWD     = 2'd2,
		MODE_WAIT    = 2'd3
	} mode_t;

	typedef enum logic [KIND_W-1:0] {
		ACC_NONE  = 2'd0,
		ACC_READ  = 2'd1,
		ACC_WRITE = 2'd2,
		ACC_ZERO  = 2'd3
	} kind_t;

	typedef struct packed {
		logic [IDX_W-1:0]   next;
		logic [START_W-1:0] start;
		mode_t              mode;
		logic [CNT_W-1:0]   x_count;
		logic [STR_W-1:0]   x_stride;
		logic [CNT_W-1:0]   y_count;
		logic [STR_W-1:0]   y_stride;
	} desc_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [IDX_W-1:0]  entry_index;
		desc_t             entry;
		logic [SDAT_W-1:0] stream_data;
	} item_t;

	typedef struct packed {
		kind_t              access_kind;
		logic [RADDR_W-1:0] ram_address;
		logic [SDAT_W-1:0]  write_data;
		logic [IDX_W-1:0]   active_entry;
	} result_t;

	typedef struct packed {
		logic             en;
		logic             clr;
		logic [IDX_W-1:0] index;
		desc_t            desc;
	} tbl_wr_t;

endpackage

[rtl/dcs_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcs_if
// Valid/ready channel interfaces: command items, results and configuration.
// ----------------------------------------------------------------------------
interface dcs_item_if import dcs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   cmd;
	logic [IDX_W-1:0]   entry_index;
	logic [IDX_W-1:0]   entry_next;
	logic [START_W-1:0] entry_start;
	logic [MODE_W-1:0]  entry_mode;
	logic [CNT_W-1:0]   entry_x_count;
	logic [STR_W-1:0]   entry_x_stride;
	logic [CNT_W-1:0]   entry_y_count;
	logic [STR_W-1:0]   entry_y_stride;
	logic [SDAT_W-1:0]  stream_data;

	modport source (
		output valid, cmd, entry_index, entry_next, entry_start, entry_mode,
			entry_x_count, entry_x_stride, entry_y_count, entry_y_stride, stream_data,
		input ready
	);
	modport sink (
		input valid, cmd, entry_index, entry_next, entry_start, entry_mode,
			entry_x_count, entry_x_stride, entry_y_count, entry_y_stride, stream_data,
		output ready
	);
endinterface

interface dcs_result_if import dcs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  access_kind;
	logic [RADDR_W-1:0] ram_address;
	logic [SDAT_W-1:0]  write_data;
	logic [IDX_W-1:0]   active_entry;

	modport source (
		output valid, access_kind, ram_address, write_data, active_entry,
		input ready
	);
	modport sink (
		input valid, access_kind, ram_address, write_data, active_entry,
		output ready
	);
endinterface

interface dcs_cfg_if ();
	logic valid;
	logic ready;
	logic direction;

	modport source (output valid, direction, input ready);
	modport sink (input valid, direction, output ready);
endinterface

[rtl/dcs_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcs_table
// Descriptor store with per-entry valid bits; invalid entries read as zero.
// ----------------------------------------------------------------------------
module dcs_table import dcs_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	localparam int TIW = $clog2(TABLE_DEPTH)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  tbl_wr_t        wr,
	input  logic [TIW-1:0] rd_index,
	output desc_t          rd_desc
);

	desc_t                  mem_q [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;
	logic                   in_range;
	logic [TIW-1:0]         wr_slot;
	logic [IDX_W-1:0]       next_mod;
	desc_t                  wr_desc;

	// links are folded into the table range once, at write time
	always_comb begin
		next_mod = wr.desc.next;
		for (int i = 0; i < 8; i++) begin
			if (32'(next_mod) >= TABLE_DEPTH)
				next_mod = next_mod - IDX_W'(TABLE_DEPTH);
		end
		wr_desc      = wr.desc;
		wr_desc.next = next_mod;
		in_range     = 32'(wr.index) < TABLE_DEPTH;
		wr_slot      = TIW'(wr.index);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.clr) begin
			valid_q <= '0;
		end else if (wr.en && in_range) begin
			valid_q[wr_slot] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && in_range)
			mem_q[wr_slot] <= wr_desc;
	end

	assign rd_desc = valid_q[rd_index] ? mem_q[rd_index] : '0;

endmodule

[rtl/dcs_seq.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// dcs_seq
// Address and count state of the current descriptor, next-state and result.
// ----------------------------------------------------------------------------
module dcs_seq import dcs_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int ADDR_WIDTH  = ADDR_WIDTH_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
	parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
	localparam int TIW = $clog2(TABLE_DEPTH)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           commit,
	input  item_t          item,
	input  logic           dir,
	input  desc_t          desc,
	output logic [TIW-1:0] rd_index,
	output tbl_wr_t        tbl_wr,
	output result_t        result
);

	logic [TIW-1:0]         cur_q, cur_d;
	logic [ADDR_WIDTH-1:0]  addr_q, addr_d;
	logic [COUNT_WIDTH-1:0] x_q, x_d, y_q, y_d;
	// pend: counters still to be loaded from the current entry
	logic                   pend_q, pend_d, force_q, force_d;

	logic [COUNT_WIDTH-1:0] xc, yc, fx, eff_x, eff_y, x_dec, x_new, y_new;
	logic [ADDR_WIDTH-1:0]  start_a, xs, ys, eff_a, a_new;
	logic                   link, step;

	assign rd_index = cur_q;

	always_comb begin
		tbl_wr.en    = commit && (item.cmd == CMD_WRITE);
		tbl_wr.clr   = commit && (item.cmd == CMD_SRST);
		tbl_wr.index = item.entry_index;
		tbl_wr.desc  = item.entry;
	end

	always_comb begin
		xc      = COUNT_WIDTH'(desc.x_count);
		yc      = COUNT_WIDTH'(desc.y_count);
		fx      = (xc == '0) ? COUNT_WIDTH'(1) : xc;
		start_a = ADDR_WIDTH'(desc.start);
		xs      = ADDR_WIDTH'(desc.x_stride);
		ys      = ADDR_WIDTH'(desc.y_stride);

		eff_x = pend_q ? fx : x_q;
		eff_y = pend_q ? yc : y_q;
		eff_a = (pend_q && (force_q || desc.mode != MODE_FWD)) ? start_a : addr_q;

		x_dec = (eff_x == '0) ? '0 : eff_x - COUNT_WIDTH'(1);
		x_new = x_dec;
		y_new = eff_y;
		a_new = eff_a;
		if (x_dec == '0) begin
			if (eff_y != '0) begin
				a_new = eff_a + ys;
				x_new = fx;
				y_new = eff_y - COUNT_WIDTH'(1);
			end
		end else begin
			a_new = eff_a + xs;
		end
		link = (x_new == '0) && (y_new == '0);
	end

	always_comb begin
		cur_d   = cur_q;
		addr_d  = eff_a;
		x_d     = eff_x;
		y_d     = eff_y;
		pend_d  = 1'b0;
		force_d = force_q;
		step    = 1'b0;
		result.access_kind = ACC_NONE;
		result.ram_address = '0;
		result.write_data  = '0;

		case (item.cmd)
			CMD_TICK: begin
				if (desc.mode inside {MODE_XFER, MODE_FWD}) begin
					step = 1'b1;
					result.ram_address = RADDR_W'(eff_a);
					if (dir) begin
						result.access_kind = ACC_WRITE;
						result.write_data  = SDAT_W'(DATA_WIDTH'(item.stream_data));
					end else begin
						result.access_kind = ACC_READ;
					end
				end else if (desc.mode == MODE_WAIT) begin
					step = 1'b1;
				end else if (!dir) begin
					result.access_kind = ACC_ZERO;
				end
			end
			CMD_START, CMD_SRST: begin
				cur_d   = '0;
				pend_d  = 1'b1;
				force_d = 1'b1;
			end
			default: begin
			end
		endcase

		if (step) begin
			addr_d = a_new;
			x_d    = x_new;
			y_d    = y_new;
			if (link) begin
				cur_d   = TIW'(desc.next);
				pend_d  = 1'b1;
				force_d = 1'b0;
			end
		end
		result.active_entry = IDX_W'(cur_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= '0;
			addr_q  <= '0;
			x_q     <= '0;
			y_q     <= '0;
			pend_q  <= 1'b0;
			force_q <= 1'b0;
		end else if (commit) begin
			cur_q   <= cur_d;
			addr_q  <= addr_d;
			x_q     <= x_d;
			y_q     <= y_d;
			pend_q  <= pend_d;
			force_q <= force_d;
		end
	end

	`DCS_ASSERT_NEXT(a_srst_home, clk, arst_n, commit && item.cmd == CMD_SRST, cur_q == '0 && pend_q && force_q, "soft reset did not return to entry zero")
	`DCS_ASSERT_NEXT(a_write_loads, clk, arst_n, commit && item.cmd == CMD_WRITE, !pend_q, "descriptor write left a counter load pending")
	`DCS_ASSERT_IMPL(a_wr_dir, clk, arst_n, commit && result.access_kind == ACC_WRITE, dir, "RAM write issued in memory-to-stream direction")
	`DCS_ASSERT_IMPL(a_idle_cmd, clk, arst_n, commit && item.cmd != CMD_TICK, result.access_kind == ACC_NONE && result.ram_address == '0 && result.write_data == '0, "non-tick request produced an access")
	`DCS_ASSERT_NEXT(a_hold, clk, arst_n, !commit, $stable(cur_q) && $stable(addr_q) && $stable(pend_q), "sequencer state moved without a request")

endmodule

[rtl/descriptor_chain_2d_dma_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// descriptor_chain_2d_dma_sequencer
// Chained-descriptor 2D DMA address sequencer, one request per clock while results are taken.
// ----------------------------------------------------------------------------
// Each request (tick, descriptor write, start, soft reset) is registered on
// entry and produces exactly one result through an output register; a new
// request is taken every cycle while the result side keeps up, so the
// sustained rate is one request per clock. A request commits, and its result
// is registered, only once the output register is free or being taken. The
// limit is the update of the running address and the x/y counters, which
// feeds back into the next request. Counters of a newly linked descriptor are
// loaded from the table on its first request, so the table is read at one
// address only. The direction register is written through its own channel,
// which is always ready, and must only be changed while no request is
// outstanding.
module descriptor_chain_2d_dma_sequencer import dcs_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int ADDR_WIDTH  = ADDR_WIDTH_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
	parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	dcs_item_if.sink     item,
	dcs_result_if.source result,
	dcs_cfg_if.sink      cfg
);

	localparam int TIW = $clog2(TABLE_DEPTH);

	item_t          item_s1;
	logic           item_v_s1;
	result_t        res_s2, res_d;
	logic           res_v_s2;
	logic           dir_q;
	logic           commit;
	desc_t          rd_desc;
	logic [TIW-1:0] rd_index;
	tbl_wr_t        tbl_wr;

	assign commit     = item_v_s1 && (!res_v_s2 || result.ready);
	assign item.ready = !item_v_s1 || commit;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_s1 <= 1'b0;
			res_v_s2  <= 1'b0;
			dir_q     <= 1'b0;
		end else begin
			if (item.ready)
				item_v_s1 <= item.valid;
			if (commit)
				res_v_s2 <= 1'b1;
			else if (result.ready)
				res_v_s2 <= 1'b0;
			if (cfg.valid)
				dir_q <= cfg.direction;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.cmd            <= cmd_t'(item.cmd);
			item_s1.entry_index    <= item.entry_index;
			item_s1.entry.next     <= item.entry_next;
			item_s1.entry.start    <= item.entry_start;
			item_s1.entry.mode     <= mode_t'(item.entry_mode);
			item_s1.entry.x_count  <= item.entry_x_count;
			item_s1.entry.x_stride <= item.entry_x_stride;
			item_s1.entry.y_count  <= item.entry_y_count;
			item_s1.entry.y_stride <= item.entry_y_stride;
			item_s1.stream_data    <= item.stream_data;
		end
		if (commit)
			res_s2 <= res_d;
	end

	dcs_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (tbl_wr),
		.rd_index(rd_index),
		.rd_desc (rd_desc)
	);

	dcs_seq #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.ADDR_WIDTH (ADDR_WIDTH),
		.COUNT_WIDTH(COUNT_WIDTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.commit  (commit),
		.item    (item_s1),
		.dir     (dir_q),
		.desc    (rd_desc),
		.rd_index(rd_index),
		.tbl_wr  (tbl_wr),
		.result  (res_d)
	);

	assign result.valid        = res_v_s2;
	assign result.access_kind  = res_s2.access_kind;
	assign result.ram_address  = res_s2.ram_address;
	assign result.write_data   = res_s2.write_data;
	assign result.active_entry = res_s2.active_entry;

endmodule
